// ----- sv/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Shared constants, codes and payload types.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int unsigned MaxChunks   = 64;
  localparam int unsigned HeaderBytes = 16;

  localparam logic       OpAlloc = 1'b0;
  localparam logic       OpFree  = 1'b1;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusNoFit    = 2'd1;
  localparam logic [1:0] StatusNotFound = 2'd2;

  localparam logic       CfgPoolStart = 1'b0;
  localparam logic       CfgPoolBytes = 1'b1;

  typedef struct packed {
    logic        op;
    logic [31:0] req_bytes;
    logic [31:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [31:0] payload_addr;
    logic [1:0]  status;
  } rsp_t;

endpackage

// ----- sv/ffha_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/first_fit_heap_allocator_core.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator core
// Address-ordered chunk table with first-fit allocate, split and coalescing.
// ----------------------------------------------------------------------------
//  channel  | signals                       | transfer when
//  req      | req_valid_i/req_ready_o/req_i | req_valid_i && req_ready_o
//  rsp      | rsp_valid_o/rsp_ready_i/rsp_o | rsp_valid_o && rsp_ready_i
//  cfg      | cfg_we_i/cfg_idx_i/cfg_data_i | cfg_we_i
//
// Each chunk scanned is read through the single RAM read port, and each
// entry moved by a split or merge is read and written back. After reset
// or a register write the table is rewritten as one free chunk with no
// clearing pass; the data of entries at or beyond the chunk count is never
// used. One request is in work at a time.
module first_fit_heap_allocator_core #(
  parameter int unsigned MaxChunks   = ffha_pkg::MaxChunks,
  parameter int unsigned HeaderBytes = ffha_pkg::HeaderBytes
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  ffha_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output ffha_pkg::rsp_t rsp_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [31:0]    cfg_data_i
);

  localparam int unsigned Aw = $clog2(MaxChunks);
  localparam int unsigned Cw = $clog2(MaxChunks + 1);
  localparam logic [31:0] Hdr = 32'(HeaderBytes);
  localparam logic [Cw-1:0] CntMax = Cw'(MaxChunks);
  localparam int unsigned Ew = 65;

  typedef enum logic [3:0] {
    StIdle, StRd, StChk, StSplit, StShRd, StShWr,
    StPrevRd, StPrev, StNextRd, StNext, StRmRd, StRmWr, StDone
  } state_e;

  state_e        state_q;
  logic [Cw-1:0] cnt_q, idx_q, j_q, hit_q;
  logic [31:0]   start_q, bytes_q;
  ffha_pkg::req_t r_q;
  logic [Ew-1:0] ent_q, new_q;
  logic          init_q;
  logic          ret_next_q;
  ffha_pkg::rsp_t rsp_q;
  logic          rsp_v_q;

  logic          we;
  logic [Aw-1:0] wa, ra;
  logic [Ew-1:0] wd, rd;

  // Entry layout: used, offset, payload.
  logic        rd_used;
  logic [31:0] rd_off, rd_pay;
  assign rd_used = rd[64];
  assign rd_off  = rd[63:32];
  assign rd_pay  = rd[31:0];

  ffha_ram #(.Width(Ew), .Depth(MaxChunks)) u_ram (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd)
  );

  logic [32:0] need;
  logic [31:0] sum;
  always_comb begin
    need = {1'b0, r_q.req_bytes} + {1'b0, Hdr} + 33'd1;
    sum  = ent_q[31:0] + rd_pay + Hdr;
  end

  always_comb begin
    we = 1'b0;
    wa = idx_q[Aw-1:0];
    wd = '0;
    ra = idx_q[Aw-1:0];
    if (init_q) begin
      we = 1'b1;
      wa = '0;
      wd = {1'b0, start_q, (bytes_q >= Hdr) ? bytes_q - Hdr : 32'd0};
    end
    case (state_q)
      StShRd:   ra = Aw'(j_q - 1'b1);
      StShWr: begin
        we = 1'b1;
        wa = j_q[Aw-1:0];
        wd = rd;
      end
      StSplit: begin
        we = 1'b1;
        wd = ent_q;
      end
      StPrevRd: ra = Aw'(idx_q - 1'b1);
      StNextRd: ra = Aw'(idx_q + 1'b1);
      StRmRd:   ra = Aw'(j_q + 1'b1);
      StRmWr: begin
        we = 1'b1;
        wa = j_q[Aw-1:0];
        wd = rd;
      end
      StDone: begin
        we = 1'b1;
        wd = ent_q;
      end
      default: ;
    endcase
  end

  assign req_ready_o = (state_q == StIdle) && !rsp_v_q && !init_q;
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= Cw'(1);
      start_q <= '0;
      bytes_q <= '0;
      init_q  <= 1'b1;
      rsp_v_q <= 1'b0;
      idx_q   <= '0;
      j_q     <= '0;
      hit_q   <= '0;
      ret_next_q <= 1'b0;
    end else begin
      init_q <= cfg_we_i;
      if (cfg_we_i) begin
        if (cfg_idx_i == ffha_pkg::CfgPoolStart) start_q <= cfg_data_i;
        else                                     bytes_q <= cfg_data_i;
        cnt_q  <= Cw'(1);
      end
      if (rsp_v_q && rsp_ready_i) rsp_v_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (req_valid_i && req_ready_o) begin
            r_q     <= req_i;
            idx_q   <= '0;
            state_q <= StRd;
          end
        end
        StRd: state_q <= StChk;
        StChk: begin
          if (r_q.op == ffha_pkg::OpAlloc) begin
            if (!rd_used && rd_pay > r_q.req_bytes) begin
              rsp_q <= '{payload_addr: rd_off + Hdr, status: ffha_pkg::StatusOk};
              if ({1'b0, rd_pay} >= need && cnt_q < CntMax) begin
                ent_q <= {1'b1, rd_off, r_q.req_bytes};
                new_q <= {1'b0, rd_off + Hdr + r_q.req_bytes,
                          rd_pay - r_q.req_bytes - Hdr};
                j_q   <= cnt_q;
                state_q <= StShRd;
              end else begin
                ent_q   <= {1'b1, rd_off, rd_pay};
                state_q <= StDone;
              end
            end else if (idx_q + 1'b1 >= cnt_q) begin
              rsp_q   <= '{payload_addr: 32'd0, status: ffha_pkg::StatusNoFit};
              rsp_v_q <= 1'b1;
              state_q <= StIdle;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= StRd;
            end
          end else begin
            if (rd_off + Hdr == r_q.free_addr) begin
              rsp_q <= '{payload_addr: 32'd0, status: ffha_pkg::StatusOk};
              ent_q <= {1'b0, rd_off, rd_pay};
              state_q <= (idx_q != '0) ? StPrevRd : StNextRd;
            end else if (idx_q + 1'b1 >= cnt_q) begin
              rsp_q   <= '{payload_addr: 32'd0, status: ffha_pkg::StatusNotFound};
              rsp_v_q <= 1'b1;
              state_q <= StIdle;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= StRd;
            end
          end
        end
        StShRd: state_q <= (j_q == idx_q + 1'b1) ? StSplit : StShWr;
        StShWr: begin
          j_q     <= j_q - 1'b1;
          state_q <= StShRd;
        end
        StSplit: begin
          ent_q   <= new_q;
          idx_q   <= idx_q + 1'b1;
          cnt_q   <= cnt_q + 1'b1;
          state_q <= StDone;
        end
        StPrevRd: state_q <= StPrev;
        StPrev: begin
          if (!rd_used) begin
            ent_q   <= {1'b0, rd_off, sum};
            hit_q   <= idx_q - 1'b1;
            j_q     <= idx_q;
            ret_next_q <= 1'b1;
            state_q <= StRmRd;
          end else begin
            state_q <= StNextRd;
          end
        end
        StNextRd: state_q <= (idx_q + 1'b1 < cnt_q) ? StNext : StDone;
        StNext: begin
          if (!rd_used) begin
            ent_q   <= {ent_q[64:32], sum};
            hit_q   <= idx_q;
            j_q     <= idx_q + 1'b1;
            ret_next_q <= 1'b0;
            state_q <= StRmRd;
          end else begin
            state_q <= StDone;
          end
        end
        StRmRd: begin
          if (j_q + 1'b1 >= cnt_q) begin
            cnt_q <= cnt_q - 1'b1;
            idx_q <= hit_q;
            state_q <= ret_next_q ? StNextRd : StDone;
          end else begin
            state_q <= StRmWr;
          end
        end
        StRmWr: begin
          j_q     <= j_q + 1'b1;
          state_q <= StRmRd;
        end
        StDone: begin
          rsp_v_q <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ----- sv/ffha_checker.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator checker
// Port-level properties of the allocator core.
// ----------------------------------------------------------------------------
module ffha_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_o,
  input logic           rsp_valid_o,
  input logic           rsp_ready_i,
  input ffha_pkg::rsp_t rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");

  a_no_ready_with_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o)
    else $error("request ready while a response waits");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o && !rsp_valid_o)
    else $error("request finished without work");

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.status == ffha_pkg::StatusOk ||
                     rsp_o.status == ffha_pkg::StatusNoFit ||
                     rsp_o.status == ffha_pkg::StatusNotFound))
    else $error("illegal status");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != ffha_pkg::StatusOk |-> rsp_o.payload_addr == 32'd0)
    else $error("failed response with an address");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
  .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i, .rsp_o
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator testbench
// Drives allocate and free requests with random gaps and response stalls,
// predicts every response from a chunk-table model and checks each transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned TableDepth = ffha_pkg::MaxChunks;
  localparam int unsigned HdrBytes   = ffha_pkg::HeaderBytes;
  localparam int unsigned RandItems  = 2000;
  localparam int unsigned CycleLimit = 4000000;

  typedef struct packed {
    logic        op;
    logic [31:0] req_bytes;
    logic [31:0] free_addr;
    logic        has_exp;
    logic [31:0] exp_addr;
    logic [1:0]  exp_status;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic req_valid_i;
  logic req_ready_o;
  ffha_pkg::req_t req_i;
  logic rsp_valid_o;
  logic rsp_ready_i;
  ffha_pkg::rsp_t rsp_o;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [31:0] cfg_data_i;

  logic [31:0] m_start;
  logic [31:0] m_bytes;
  logic [31:0] m_off [TableDepth];
  logic [31:0] m_pay [TableDepth];
  logic        m_used [TableDepth];
  int unsigned m_count;

  ffha_pkg::rsp_t pending_rsp [$];
  logic [31:0] live_addrs [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  first_fit_heap_allocator_core uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic void table_init();
    for (int i = 0; i < TableDepth; i++) begin
      m_off[i] = '0;
      m_pay[i] = '0;
      m_used[i] = 1'b0;
    end
    m_off[0] = m_start;
    m_pay[0] = (m_bytes >= HdrBytes) ? m_bytes - HdrBytes : 32'd0;
    m_count = 1;
  endfunction

  function automatic void table_remove(int unsigned idx);
    for (int unsigned j = idx; j + 1 < m_count; j++) begin
      m_off[j] = m_off[j+1];
      m_pay[j] = m_pay[j+1];
      m_used[j] = m_used[j+1];
    end
    m_count--;
    m_off[m_count] = '0;
    m_pay[m_count] = '0;
    m_used[m_count] = 1'b0;
  endfunction

  function automatic ffha_pkg::rsp_t heap_predict(ffha_pkg::req_t r);
    ffha_pkg::rsp_t o;
    int unsigned    i;
    logic [32:0]    need;
    o.payload_addr = '0;
    if (r.op == ffha_pkg::OpAlloc) begin
      for (i = 0; i < m_count; i++)
        if (!m_used[i] && m_pay[i] > r.req_bytes) break;
      if (i >= m_count) begin
        o.status = ffha_pkg::StatusNoFit;
        return o;
      end
      need = {1'b0, r.req_bytes} + HdrBytes + 1;
      if ({1'b0, m_pay[i]} >= need && m_count < TableDepth) begin
        for (int unsigned j = m_count; j > i + 1; j--) begin
          m_off[j] = m_off[j-1];
          m_pay[j] = m_pay[j-1];
          m_used[j] = m_used[j-1];
        end
        m_off[i+1] = m_off[i] + HdrBytes + r.req_bytes;
        m_pay[i+1] = m_pay[i] - r.req_bytes - HdrBytes;
        m_used[i+1] = 1'b0;
        m_count++;
        m_pay[i] = r.req_bytes;
      end
      m_used[i] = 1'b1;
      o.payload_addr = m_off[i] + HdrBytes;
      o.status = ffha_pkg::StatusOk;
    end else begin
      for (i = 0; i < m_count; i++)
        if (m_off[i] + HdrBytes == r.free_addr) break;
      if (i >= m_count) begin
        o.status = ffha_pkg::StatusNotFound;
        return o;
      end
      m_used[i] = 1'b0;
      if (i > 0 && !m_used[i-1]) begin
        m_pay[i-1] = m_pay[i-1] + m_pay[i] + HdrBytes;
        table_remove(i);
        i--;
      end
      if (i + 1 < m_count && !m_used[i+1]) begin
        m_pay[i] = m_pay[i] + m_pay[i+1] + HdrBytes;
        table_remove(i + 1);
      end
      o.status = ffha_pkg::StatusOk;
    end
    return o;
  endfunction

  task automatic reg_write(logic idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ffha_pkg::CfgPoolStart) m_start = val;
    else m_bytes = val;
    table_init();
    live_addrs.delete();
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (4 * TableDepth + 8) @(posedge clk_i);
  endtask

  // Rows with a typed expectation are checked against that value.
  task automatic send_req(ffha_pkg::req_t r, bit has_exp, logic [31:0] ea,
                          logic [1:0] es);
    ffha_pkg::rsp_t p;
    repeat ($urandom_range(0, 10)) @(posedge clk_i);
    req_valid_i <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    req_valid_i <= 1'b0;
    p = heap_predict(r);
    if (has_exp) begin
      p.payload_addr = ea;
      p.status = es;
    end
    pending_rsp.push_back(p);
    if (r.op == ffha_pkg::OpAlloc && p.status == ffha_pkg::StatusOk)
      live_addrs.push_back(p.payload_addr);
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned wait_cnt;
    rsp_ready_i = 1'b1;
    stall_loop: forever begin
      @(posedge clk_i);
      if (rsp_ready_i && rsp_valid_o) begin
        wait_cnt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (wait_cnt != 0) rsp_ready_i <= 1'b0;
      end else if (!rsp_ready_i) begin
        if (wait_cnt != 0) wait_cnt--;
        if (wait_cnt == 0) rsp_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    ffha_pkg::rsp_t e;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %h/%0d",
                                       rsp_o.payload_addr, rsp_o.status);
      end else begin
        e = pending_rsp.pop_front();
        if (e.payload_addr != rsp_o.payload_addr || e.status != rsp_o.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                     e.payload_addr, e.status, rsp_o.payload_addr, rsp_o.status);
        end
      end
    end
  end

  stim_row_t directed [] = '{
    '{ffha_pkg::OpAlloc, 32'd0, 32'd0,         1'b1, 32'h0, ffha_pkg::StatusNoFit},
    '{ffha_pkg::OpFree,  32'd0, 32'h10,        1'b1, 32'h0, ffha_pkg::StatusOk},
    '{ffha_pkg::OpFree,  32'd0, 32'hFFFF_FFFF, 1'b1, 32'h0, ffha_pkg::StatusNotFound}
  };

  stim_row_t pool_rows [] = '{
    '{ffha_pkg::OpAlloc, 32'd0,         32'd0,         1'b0, 32'h0, ffha_pkg::StatusOk},
    '{ffha_pkg::OpAlloc, 32'd100,       32'd0,         1'b0, 32'h0, ffha_pkg::StatusOk},
    '{ffha_pkg::OpAlloc, 32'hFFFF_FFFF, 32'd0,         1'b1, 32'h0, ffha_pkg::StatusNoFit},
    '{ffha_pkg::OpAlloc, 32'd5,         32'd0,         1'b0, 32'h0, ffha_pkg::StatusOk},
    '{ffha_pkg::OpFree,  32'd0, 32'h1234_5677, 1'b1, 32'h0, ffha_pkg::StatusNotFound},
    '{ffha_pkg::OpFree,  32'd0,         32'h1234_5688, 1'b0, 32'h0, ffha_pkg::StatusOk},
    '{ffha_pkg::OpFree,  32'd0,         32'h1234_5688, 1'b0, 32'h0, ffha_pkg::StatusOk},
    '{ffha_pkg::OpAlloc, 32'd1,         32'd0,         1'b0, 32'h0, ffha_pkg::StatusOk},
    '{ffha_pkg::OpAlloc, 32'd3,         32'd0,         1'b0, 32'h0, ffha_pkg::StatusOk},
    '{ffha_pkg::OpFree,  32'd0,         32'h1234_5678, 1'b0, 32'h0, ffha_pkg::StatusOk},
    '{ffha_pkg::OpFree,  32'd0,         32'h1234_568D, 1'b0, 32'h0, ffha_pkg::StatusOk},
    '{ffha_pkg::OpAlloc, 32'd900,       32'd0,         1'b0, 32'h0, ffha_pkg::StatusOk}
  };

  initial begin
    ffha_pkg::req_t r;
    logic [31:0] sizes [4];
    logic [31:0] starts [4];
    int unsigned k;
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ffha_pkg::CfgPoolStart;
    cfg_data_i = '0;
    m_start = '0;
    m_bytes = '0;
    table_init();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset pool: zero bytes, so every allocate fails.
    foreach (directed[n]) begin
      r = '{directed[n].op, directed[n].req_bytes, directed[n].free_addr};
      send_req(r, directed[n].has_exp, directed[n].exp_addr, directed[n].exp_status);
    end
    wait_idle();

    // Small pool below one header.
    reg_write(ffha_pkg::CfgPoolBytes, 32'd15);
    send_req(ffha_pkg::req_t'{ffha_pkg::OpAlloc, 32'd0, 32'd0}, 1'b1, 32'h0,
             ffha_pkg::StatusNoFit);
    wait_idle();

    reg_write(ffha_pkg::CfgPoolStart, 32'h1234_5678);
    reg_write(ffha_pkg::CfgPoolBytes, 32'd1000);
    foreach (pool_rows[n]) begin
      r = '{pool_rows[n].op, pool_rows[n].req_bytes, pool_rows[n].free_addr};
      send_req(r, pool_rows[n].has_exp, pool_rows[n].exp_addr, pool_rows[n].exp_status);
    end
    wait_idle();

    // Phases: wrapping pools, the maximum pool and a fill of the table.
    starts = '{32'hFFFF_FF00, 32'h0, 32'hA5A5_0000, 32'hFFFF_FFFF};
    sizes  = '{32'h0000_4000, 32'hFFFF_FFFF, 32'd3000, 32'd2048};
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(ffha_pkg::CfgPoolStart, starts[ph]);
      reg_write(ffha_pkg::CfgPoolBytes, sizes[ph]);
      for (int n = 0; n < RandItems / 4; n++) begin
        k = $urandom_range(0, 99);
        r.req_bytes = $urandom;
        r.free_addr = $urandom;
        if (k < 50) begin
          r.op = ffha_pkg::OpAlloc;
          if (k < 45) r.req_bytes = $urandom_range(0, (ph == 1) ? 400 : 60);
        end else begin
          r.op = ffha_pkg::OpFree;
          if (k < 90 && live_addrs.size() != 0) begin
            k = $urandom_range(0, live_addrs.size() - 1);
            r.free_addr = live_addrs[k];
            live_addrs.delete(k);
          end else if (k < 95) begin
            r.free_addr = starts[ph] + HdrBytes;
          end
        end
        send_req(r, 1'b0, 32'h0, ffha_pkg::StatusOk);
      end
      wait_idle();
    end

    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ffha_pkg.sv
sv/ffha_ram.sv
sv/first_fit_heap_allocator_core.sv
sv/ffha_checker.sv
tb/sv/testbench.sv
